// ===== design/polyline_cumulative_arc_length_defines.svh =====
// Assertion macros shared by the arc length design files.
`ifndef POLYLINE_CUMULATIVE_ARC_LENGTH_DEFINES_SVH
`define POLYLINE_CUMULATIVE_ARC_LENGTH_DEFINES_SVH

// same-cycle implication
`define PCAL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pcal check failed");

// next-cycle implication
`define PCAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pcal check failed");

`endif

// ===== design/pcal_pkg.sv =====
// Shared widths and types for the polyline arc length block.
`default_nettype none
package pcal_pkg;
	localparam int COORD_BITS  = 24;
	localparam int LENGTH_BITS = 32;
	localparam int DIFF_BITS   = COORD_BITS + 1;
	localparam int SQ_BITS     = 2 * DIFF_BITS;
	localparam int RAD_BITS    = SQ_BITS;
	localparam int ROOT_BITS   = RAD_BITS / 2;
	localparam int REM_BITS    = ROOT_BITS + 2;
	localparam int ITER_BITS   = $clog2(ROOT_BITS);
	localparam int QDEPTH      = 4;
	localparam int QPTR_BITS   = $clog2(QDEPTH);

	localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

	typedef struct packed {
		logic [DIFF_BITS-1:0] adx;
		logic [DIFF_BITS-1:0] ady;
		logic                 first;
		logic                 last;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;
endpackage
`default_nettype wire

// ===== design/polyline_cumulative_arc_length.sv =====
// Top level of the polyline cumulative arc length block.
//
//  channel  valid      stall       payload
//  in       in_valid   in_stall    point_x, point_y, first_point, last_point
//  out      out_valid  out_stall   distance_along, saturated, last_out
//
// In pcal_back a point passes IDLE, SQUARE, ADD, ROOT and ACC;
// ROOT is the 25-step bit-serial square root. A first point skips to ACC.
// The front end takes up to 4 points ahead of the back end into the queue.
// arst_n clears the queue, the previous point to (0,0) and the sum to 0.
// in_stall rises while the queue is full; out_stall holds the output register.
`default_nettype none
module polyline_cumulative_arc_length (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [pcal_pkg::COORD_BITS-1:0] point_x,
	input  wire logic signed [pcal_pkg::COORD_BITS-1:0] point_y,
	input  wire logic                                   first_point,
	input  wire logic                                   last_point,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic [pcal_pkg::LENGTH_BITS-1:0]            distance_along,
	output logic                                        saturated,
	output logic                                        last_out
);
	pcal_pkg::q_status_t q_status;
	pcal_pkg::entry_t    push_entry, pop_entry;
	logic                q_push, q_pop;

	pcal_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.point_x     (point_x),
		.point_y     (point_y),
		.first_point (first_point),
		.last_point  (last_point),
		.q_status    (q_status),
		.q_push      (q_push),
		.q_entry     (push_entry)
	);

	pcal_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.pop        (q_pop),
		.pop_entry  (pop_entry),
		.status     (q_status)
	);

	pcal_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_status       (q_status),
		.q_entry        (pop_entry),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.distance_along (distance_along),
		.saturated      (saturated),
		.last_out       (last_out)
	);
endmodule
`default_nettype wire

// ===== design/pcal_front.sv =====
// Front end: accepts points and forms coordinate difference magnitudes.
`default_nettype none
module pcal_front (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [pcal_pkg::COORD_BITS-1:0] point_x,
	input  wire logic signed [pcal_pkg::COORD_BITS-1:0] point_y,
	input  wire logic                                   first_point,
	input  wire logic                                   last_point,
	input  wire pcal_pkg::q_status_t                    q_status,
	output logic                                        q_push,
	output pcal_pkg::entry_t                            q_entry
);
	logic [pcal_pkg::COORD_BITS-1:0] prev_x_q, prev_y_q;
	logic [pcal_pkg::DIFF_BITS-1:0]  dx, dy;

	assign in_stall = q_status.full;
	assign q_push   = in_valid && !in_stall;

	assign dx = {point_x[pcal_pkg::COORD_BITS-1], point_x}
		- {prev_x_q[pcal_pkg::COORD_BITS-1], prev_x_q};
	assign dy = {point_y[pcal_pkg::COORD_BITS-1], point_y}
		- {prev_y_q[pcal_pkg::COORD_BITS-1], prev_y_q};

	always_comb begin
		q_entry.adx   = dx[pcal_pkg::DIFF_BITS-1] ? (~dx + 1'b1) : dx;
		q_entry.ady   = dy[pcal_pkg::DIFF_BITS-1] ? (~dy + 1'b1) : dy;
		q_entry.first = first_point;
		q_entry.last  = last_point;
	end

	// previous point tracks every transfer, first point or not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else if (q_push) begin
			prev_x_q <= point_x;
			prev_y_q <= point_y;
		end
	end
endmodule
`default_nettype wire

// ===== design/pcal_queue.sv =====
// Small queue between front end and back end.
`default_nettype none
`include "polyline_cumulative_arc_length_defines.svh"
module pcal_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire pcal_pkg::entry_t push_entry,
	input  wire logic             pop,
	output pcal_pkg::entry_t      pop_entry,
	output pcal_pkg::q_status_t   status
);
	pcal_pkg::entry_t                mem_q [pcal_pkg::QDEPTH];
	logic [pcal_pkg::QPTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
	logic [pcal_pkg::QPTR_BITS:0]    count_q;

	assign status.full  = (count_q == (pcal_pkg::QPTR_BITS+1)'(pcal_pkg::QDEPTH));
	assign status.empty = (count_q == '0);
	assign pop_entry    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`PCAL_ASSERT_NOW(a_no_push_full, clk, arst_n, push, !status.full)
	`PCAL_ASSERT_NOW(a_no_pop_empty, clk, arst_n, pop, !status.empty)
	`PCAL_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1,
		count_q <= (pcal_pkg::QPTR_BITS+1)'(pcal_pkg::QDEPTH))
endmodule
`default_nettype wire

// ===== design/pcal_back.sv =====
// Back end: squares, bit-serial square root, saturating accumulate, output register.
`default_nettype none
`include "polyline_cumulative_arc_length_defines.svh"
module pcal_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire pcal_pkg::q_status_t             q_status,
	input  wire pcal_pkg::entry_t                q_entry,
	output logic                                 q_pop,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [pcal_pkg::LENGTH_BITS-1:0]     distance_along,
	output logic                                 saturated,
	output logic                                 last_out
);
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SQUARE = 5'b00010,
		ST_ADD    = 5'b00100,
		ST_ROOT   = 5'b01000,
		ST_ACC    = 5'b10000
	} state_t;

	state_t                           state_q;
	logic [pcal_pkg::DIFF_BITS-1:0]   adx_q, ady_q;
	logic                             first_q, last_q;
	logic [pcal_pkg::SQ_BITS-1:0]     sqx_q, sqy_q;
	logic [pcal_pkg::RAD_BITS-1:0]    rad_q;
	logic [pcal_pkg::REM_BITS-1:0]    rem_q;
	logic [pcal_pkg::ROOT_BITS-1:0]   root_q;
	logic [pcal_pkg::ITER_BITS-1:0]   iter_q;
	logic [pcal_pkg::LENGTH_BITS-1:0] run_q;
	logic                             stuck_q;
	logic                             out_valid_q;
	logic [pcal_pkg::LENGTH_BITS-1:0] dist_q;
	logic                             sat_q, last_out_q;

	logic [pcal_pkg::REM_BITS-1:0]    rem_sh, trial;
	logic                             ge;
	logic [pcal_pkg::LENGTH_BITS:0]   acc_sum;
	logic                             sat_now;
	logic [pcal_pkg::LENGTH_BITS-1:0] new_len;
	logic                             new_stuck;
	logic                             out_free, load;

	assign q_pop = (state_q == ST_IDLE) && !q_status.empty;

	// one root bit per step, two radicand bits shifted in
	assign rem_sh = {rem_q[pcal_pkg::REM_BITS-3:0], rad_q[pcal_pkg::RAD_BITS-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign ge     = (rem_sh >= trial);

	assign acc_sum   = {1'b0, run_q} + (pcal_pkg::LENGTH_BITS+1)'(root_q);
	assign sat_now   = (acc_sum >= {1'b0, pcal_pkg::LENGTH_MAX});
	assign new_len   = first_q ? '0 :
		(sat_now ? pcal_pkg::LENGTH_MAX : acc_sum[pcal_pkg::LENGTH_BITS-1:0]);
	assign new_stuck = first_q ? 1'b0 : (stuck_q | sat_now);

	assign out_free = !out_valid_q || !out_stall;
	assign load     = (state_q == ST_ACC) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			run_q       <= '0;
			stuck_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= q_entry.first ? ST_ACC : ST_SQUARE;
					end
				end
				ST_SQUARE: state_q <= ST_ADD;
				ST_ADD: begin
					iter_q  <= pcal_pkg::ITER_BITS'(pcal_pkg::ROOT_BITS - 1);
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					iter_q <= iter_q - 1'b1;
					if (iter_q == '0) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (load) begin
						run_q   <= new_len;
						stuck_q <= new_stuck;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			adx_q   <= q_entry.adx;
			ady_q   <= q_entry.ady;
			first_q <= q_entry.first;
			last_q  <= q_entry.last;
		end
		if (state_q == ST_SQUARE) begin
			sqx_q <= adx_q * adx_q;
			sqy_q <= ady_q * ady_q;
		end
		if (state_q == ST_ADD) begin
			rad_q  <= sqx_q + sqy_q;
			rem_q  <= '0;
			root_q <= '0;
		end
		if (state_q == ST_ROOT) begin
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[pcal_pkg::ROOT_BITS-2:0], ge};
			rad_q  <= {rad_q[pcal_pkg::RAD_BITS-3:0], 2'b00};
		end
		if (load) begin
			dist_q     <= new_len;
			sat_q      <= new_stuck;
			last_out_q <= last_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign distance_along = dist_q;
	assign saturated      = sat_q;
	assign last_out       = last_out_q;

	`PCAL_ASSERT_NOW(a_sat_pinned, clk, arst_n, out_valid_q && sat_q,
		dist_q == pcal_pkg::LENGTH_MAX)
	`PCAL_ASSERT_NEXT(a_first_zero, clk, arst_n, load && first_q,
		(dist_q == '0) && !sat_q && (run_q == '0))
	`PCAL_ASSERT_NOW(a_stuck_holds_max, clk, arst_n, stuck_q,
		run_q == pcal_pkg::LENGTH_MAX)
endmodule
`default_nettype wire
